>>> rtl/fmtsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte classifiers for the format spec parser.
// No dependencies; imported by format_spec_parser_top.
package fmtsp_pkg;

    // Digit width of the width/precision accumulators before saturation.
    localparam int unsigned NUM_BITS  = 16;
    localparam int unsigned LIMIT_INT = (NUM_BITS >= 16) ? 65535 : ((1 << NUM_BITS) - 1);
    localparam logic [15:0] WIDTH_LIMIT = 16'(LIMIT_INT);

    localparam logic [7:0] USED_MAX = 8'hFF;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FLAGS = 3'd1,
        PH_WIDTH = 3'd2,
        PH_PREC  = 3'd3,
        PH_AFTL  = 3'd4,
        PH_AFTH  = 3'd5,
        PH_CONV  = 3'd6
    } t_phase;

    // Length modifier codes
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_H    = 3'd1;
    localparam logic [2:0] LEN_HH   = 3'd2;
    localparam logic [2:0] LEN_L    = 3'd3;
    localparam logic [2:0] LEN_LL   = 3'd4;
    localparam logic [2:0] LEN_J    = 3'd5;
    localparam logic [2:0] LEN_Z    = 3'd6;

    // Characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;

    // Flag bit positions in the flag mask
    localparam int unsigned FB_HASH  = 0;
    localparam int unsigned FB_SPACE = 1;
    localparam int unsigned FB_PLUS  = 2;
    localparam int unsigned FB_MINUS = 3;
    localparam int unsigned FB_ZERO  = 4;

    // Result item layout on the master tdata bus
    typedef struct packed {
        logic [4:0]  pad;
        logic        end_consumed;
        logic [7:0]  bytes_used;
        logic        conv_found;
        logic [7:0]  conv_char;
        logic [2:0]  length_code;
        logic        prec_given;
        logic [15:0] prec_value;
        logic [15:0] field_width;
        logic [4:0]  flag_bits;
    } t_result;

    function automatic logic [4:0] flag_bit(input logic [7:0] c);
        logic [4:0] m;
        m = '0;
        case (c)
            CH_HASH:  m[FB_HASH]  = 1'b1;
            CH_SPACE: m[FB_SPACE] = 1'b1;
            CH_PLUS:  m[FB_PLUS]  = 1'b1;
            CH_MINUS: m[FB_MINUS] = 1'b1;
            CH_ZERO:  m[FB_ZERO]  = 1'b1;
            default:  m = '0;
        endcase
        return m;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Conversion set: s S p d D i o O u U x X c C %
    function automatic logic is_conv(input logic [7:0] c);
        logic r;
        case (c)
            8'h73, 8'h53, 8'h70, 8'h64, 8'h44, 8'h69, 8'h6F, 8'h4F,
            8'h75, 8'h55, 8'h78, 8'h58, 8'h63, 8'h43, 8'h25: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // acc * 10 + digit, held at WIDTH_LIMIT
    function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
        logic [19:0] v;
        logic [3:0]  d;
        d = 4'(c - CH_ZERO);
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
        return (v > {4'd0, WIDTH_LIMIT}) ? WIDTH_LIMIT : v[15:0];
    endfunction

endpackage

>>> rtl/format_spec_parser_top.sv
`timescale 1ns / 1ps
// Format spec parser: one byte per item after a percent sign, one result per spec.
// A result appears on the master side in the cycle after the byte that ends the spec.
// Throughput: one byte per cycle; a waiting result holds the input until it is taken.
// The per-byte state update is one short decode plus a multiply-by-ten add.
// Reset (i_rst_n low, synchronous): parser idle, accumulators cleared, no result pending.
// Depends on fmtsp_pkg.
module format_spec_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tuser,   // [0] first
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [4:0] flag_bits, [20:5] field_width,
                                        // [36:21] prec_value, [37] prec_given,
                                        // [40:38] length_code, [48:41] conv_char,
                                        // [49] conv_found, [57:50] bytes_used,
                                        // [58] end_consumed, [63:59] zero
);
    import fmtsp_pkg::*;

    // Parser state
    t_phase      r_phase,  n_phase;
    logic [4:0]  r_flag,   n_flag;
    logic [15:0] r_width,  n_width;
    logic [15:0] r_prec,   n_prec;
    logic        r_dot,    n_dot;
    logic [2:0]  r_len,    n_len;
    logic [7:0]  r_used,   n_used;

    // Output register
    logic        r_out_valid, n_out_valid;
    t_result     r_out_data,  n_out_data;

    logic        w_in_ready;
    logic        w_accept;
    logic        w_first;
    logic [7:0]  w_ch;
    t_phase      w_eff_phase;

    // Starting values for this byte: a first byte opens a clean spec
    logic [4:0]  w_b_flag;
    logic [15:0] w_b_width;
    logic [15:0] w_b_prec;
    logic        w_b_dot;
    logic [2:0]  w_b_len;
    logic [7:0]  w_b_used;

    // Byte decode
    logic        w_digit;
    logic [4:0]  w_fbit;
    logic        w_st_flags, w_st_width, w_st_len, w_st_conv;
    logic        w_do_flag, w_do_wdig, w_do_dot, w_do_pdig;
    logic        w_do_l, w_do_h, w_do_j, w_do_z, w_do_ll, w_do_hh, w_do_conv;
    logic        w_consumed;
    logic        w_res_valid;
    t_phase      w_after_len, w_after_width, w_step_phase;

    // Handshake: input is free whenever the output slot is empty or draining
    assign w_in_ready    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_in_ready;
    assign w_accept      = s_axis_tvalid && w_in_ready;
    assign w_first       = s_axis_tuser;
    assign w_ch          = s_axis_tdata;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_eff_phase = w_first ? PH_FLAGS : r_phase;
    assign w_b_flag    = w_first ? 5'd0     : r_flag;
    assign w_b_width   = w_first ? 16'd0    : r_width;
    assign w_b_prec    = w_first ? 16'd0    : r_prec;
    assign w_b_dot     = w_first ? 1'b0     : r_dot;
    assign w_b_len     = w_first ? LEN_NONE : r_len;
    assign w_b_used    = w_first ? 8'd0     : r_used;

    // Walk the byte through the parse order: flags, width, dot, precision,
    // length, second length letter, conversion. A byte that misses one
    // stage falls into the next within the same cycle.
    always_comb begin
        w_digit    = is_digit(w_ch);
        w_fbit     = flag_bit(w_ch);

        w_st_flags = (w_eff_phase == PH_FLAGS);
        w_do_flag  = w_st_flags && (w_fbit != 5'd0);
        w_st_width = (w_st_flags && (w_fbit == 5'd0)) || (w_eff_phase == PH_WIDTH);
        w_do_wdig  = w_st_width && w_digit;
        w_do_dot   = w_st_width && !w_digit && (w_ch == CH_DOT);
        w_do_pdig  = (w_eff_phase == PH_PREC) && w_digit;
        w_st_len   = (w_st_width && !w_digit && (w_ch != CH_DOT))
                   || ((w_eff_phase == PH_PREC) && !w_digit);
        w_do_l     = w_st_len && (w_ch == CH_L);
        w_do_h     = w_st_len && (w_ch == CH_H);
        w_do_j     = w_st_len && (w_ch == CH_J);
        w_do_z     = w_st_len && (w_ch == CH_Z);
        w_do_ll    = (w_eff_phase == PH_AFTL) && (w_ch == CH_L);
        w_do_hh    = (w_eff_phase == PH_AFTH) && (w_ch == CH_H);
        w_st_conv  = (w_st_len && !(w_do_l || w_do_h || w_do_j || w_do_z))
                   || ((w_eff_phase == PH_AFTL) && !w_do_ll)
                   || ((w_eff_phase == PH_AFTH) && !w_do_hh)
                   || (w_eff_phase == PH_CONV);
        w_do_conv  = w_st_conv && is_conv(w_ch);
        w_consumed = w_do_flag || w_do_wdig || w_do_dot || w_do_pdig || w_do_l
                   || w_do_h || w_do_j || w_do_z || w_do_ll || w_do_hh || w_do_conv;
    end

    // Next phase
    always_comb begin
        w_after_len   = w_do_l ? PH_AFTL
                      : w_do_h ? PH_AFTH
                      : (w_do_j || w_do_z) ? PH_CONV
                      : PH_IDLE;
        w_after_width = w_do_wdig ? PH_WIDTH
                      : w_do_dot ? PH_PREC
                      : w_after_len;
        unique case (w_eff_phase)
            PH_IDLE:  w_step_phase = PH_IDLE;
            PH_FLAGS: w_step_phase = w_do_flag ? PH_FLAGS : w_after_width;
            PH_WIDTH: w_step_phase = w_after_width;
            PH_PREC:  w_step_phase = w_do_pdig ? PH_PREC : w_after_len;
            PH_AFTL:  w_step_phase = w_do_ll ? PH_CONV : PH_IDLE;
            PH_AFTH:  w_step_phase = w_do_hh ? PH_CONV : PH_IDLE;
            PH_CONV:  w_step_phase = PH_IDLE;
            default:  w_step_phase = PH_IDLE;
        endcase
        n_phase = w_accept ? w_step_phase : r_phase;
    end

    // Accumulators, result and output slot
    always_comb begin
        n_flag  = r_flag;
        n_width = r_width;
        n_prec  = r_prec;
        n_dot   = r_dot;
        n_len   = r_len;
        n_used  = r_used;
        if (w_accept && (w_eff_phase != PH_IDLE)) begin
            n_flag  = w_b_flag | (w_do_flag ? w_fbit : 5'd0);
            n_width = w_do_wdig ? acc_digit(w_b_width, w_ch) : w_b_width;
            n_prec  = w_do_pdig ? acc_digit(w_b_prec, w_ch) : w_b_prec;
            n_dot   = w_b_dot || w_do_dot;
            n_len   = w_do_l  ? LEN_L
                    : w_do_h  ? LEN_H
                    : w_do_j  ? LEN_J
                    : w_do_z  ? LEN_Z
                    : w_do_ll ? LEN_LL
                    : w_do_hh ? LEN_HH
                    : w_b_len;
            n_used  = (w_consumed && (w_b_used != USED_MAX)) ? (w_b_used + 8'd1) : w_b_used;
        end

        w_res_valid = w_accept && w_st_conv;

        n_out_data              = r_out_data;
        if (w_res_valid) begin
            n_out_data.pad          = '0;
            n_out_data.flag_bits    = n_flag;
            n_out_data.field_width  = n_width;
            n_out_data.prec_value   = n_prec;
            n_out_data.prec_given   = n_dot;
            n_out_data.length_code  = n_len;
            n_out_data.conv_char    = w_do_conv ? w_ch : 8'd0;
            n_out_data.conv_found   = w_do_conv;
            n_out_data.bytes_used   = n_used;
            n_out_data.end_consumed = w_do_conv;
        end
        // Refill or empty the slot whenever the input side may move
        n_out_valid = w_in_ready ? w_res_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_flag      <= '0;
            r_width     <= '0;
            r_prec      <= '0;
            r_dot       <= 1'b0;
            r_len       <= LEN_NONE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_flag      <= n_flag;
            r_width     <= n_width;
            r_prec      <= n_prec;
            r_dot       <= n_dot;
            r_len       <= n_len;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // A byte that ends a spec returns the parser to idle
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> (r_phase == PH_IDLE))
        else $error("parser not idle after spec end");

    // A stray byte while idle starts nothing
    a_idle_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_first && (r_phase == PH_IDLE)) |-> !w_res_valid ##1 (r_phase == PH_IDLE))
        else $error("stray byte left idle");

    // A found conversion always counts at least its own byte
    a_conv_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.conv_found) |->
            (r_out_data.end_consumed && (r_out_data.bytes_used != 8'd0)))
        else $error("conversion result without consumed byte");

    // Digit accumulators never pass the limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_width <= WIDTH_LIMIT) && (r_prec <= WIDTH_LIMIT)))
        else $error("width or precision over limit");

endmodule

>>> sim/format_spec_parser_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for format_spec_parser_top: feeds bytes of printf specs and
// compares each result item against an in-bench parse of the same bytes, or against the expected result of a typed row.
// Depends on fmtsp_pkg and format_spec_parser_top.
module format_spec_parser_top_tb;
    import fmtsp_pkg::*;

    // One row of the directed stimulus; typed rows carry their expected result.
    typedef struct {
        logic [7:0] ch;
        logic       first;
        bit         typed;
        t_result    res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] ch
    logic        s_axis_tuser = 1'b0;   // [0] first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // t_result layout, flag_bits in the lowest bits

    // Parse state of the in-bench spec parser
    t_phase      spec_phase = PH_IDLE;
    logic [4:0]  spec_flags = '0;
    logic [15:0] spec_width = '0;
    logic [15:0] spec_prec = '0;
    logic        spec_dot = 1'b0;
    logic [2:0]  spec_len = LEN_NONE;
    logic [7:0]  spec_used = '0;

    t_result     pending_specs[$];
    t_stim_row   directed_tbl[$];
    int          useful_items = 0;
    int          fail_cnt = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    t_result     got_spec;
    t_result     want_spec;

    string       flag_chars = "# +-0";
    string       conv_chars = "sSpdDioOuUxXcC%";

    format_spec_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [4:0] flag_mask_of(input logic [7:0] c);
        case (c)
            CH_HASH:  return 5'b00001;
            CH_SPACE: return 5'b00010;
            CH_PLUS:  return 5'b00100;
            CH_MINUS: return 5'b01000;
            CH_ZERO:  return 5'b10000;
            default:  return 5'b00000;
        endcase
    endfunction

    function automatic bit is_conversion(input logic [7:0] c);
        case (c)
            "s", "S", "p", "d", "D", "i", "o", "O",
            "u", "U", "x", "X", "c", "C", "%": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // acc * 10 + digit, held at the width limit
    function automatic logic [15:0] times_ten_plus(input logic [15:0] acc, input logic [7:0] c);
        int unsigned v;
        v = acc * 10 + (c - CH_ZERO);
        return (v > WIDTH_LIMIT) ? WIDTH_LIMIT : v[15:0];
    endfunction

    function automatic void count_used();
        if (spec_used != USED_MAX) spec_used++;
    endfunction

    function automatic t_result spec_result(input logic [4:0] f, input logic [15:0] w,
                                            input logic [15:0] p, input logic d,
                                            input logic [2:0] l, input logic [7:0] cc,
                                            input logic found, input logic [7:0] used,
                                            input logic endc);
        t_result r;
        r = '0;
        r.flag_bits    = f;
        r.field_width  = w;
        r.prec_value   = p;
        r.prec_given   = d;
        r.length_code  = l;
        r.conv_char    = cc;
        r.conv_found   = found;
        r.bytes_used   = used;
        r.end_consumed = endc;
        return r;
    endfunction

    // Advance the parse by one byte; return 1 when the byte ends a spec.
    function automatic bit parse_spec_byte(input logic [7:0] c, input logic first,
                                           output t_result r);
        t_phase st;
        bit     at_len;
        bit     hit;
        r = '0;
        at_len = 1'b0;
        if (first) begin
            spec_flags = '0;
            spec_width = '0;
            spec_prec  = '0;
            spec_dot   = 1'b0;
            spec_len   = LEN_NONE;
            spec_used  = '0;
            spec_phase = PH_FLAGS;
        end else if (spec_phase == PH_IDLE) begin
            return 1'b0;
        end
        st = spec_phase;

        if (st == PH_FLAGS) begin
            if (flag_mask_of(c) != 0) begin
                spec_flags |= flag_mask_of(c);
                count_used();
                return 1'b0;
            end
            st = PH_WIDTH;
        end
        if (st == PH_WIDTH) begin
            if (is_dec(c)) begin
                spec_width = times_ten_plus(spec_width, c);
                count_used();
                spec_phase = PH_WIDTH;
                return 1'b0;
            end
            if (c == CH_DOT) begin
                spec_dot = 1'b1;
                count_used();
                spec_phase = PH_PREC;
                return 1'b0;
            end
            // anything else falls through to the length modifier
            at_len = 1'b1;
        end else if (st == PH_PREC) begin
            if (is_dec(c)) begin
                spec_prec = times_ten_plus(spec_prec, c);
                count_used();
                return 1'b0;
            end
            at_len = 1'b1;
        end

        hit = 1'b0;
        if (at_len) begin
            hit = 1'b1;
            case (c)
                CH_L: begin spec_len = LEN_L; spec_phase = PH_AFTL; end
                CH_H: begin spec_len = LEN_H; spec_phase = PH_AFTH; end
                CH_J: begin spec_len = LEN_J; spec_phase = PH_CONV; end
                CH_Z: begin spec_len = LEN_Z; spec_phase = PH_CONV; end
                default: hit = 1'b0;
            endcase
        end else if (st == PH_AFTL && c == CH_L) begin
            hit = 1'b1;
            spec_len = LEN_LL;
            spec_phase = PH_CONV;
        end else if (st == PH_AFTH && c == CH_H) begin
            hit = 1'b1;
            spec_len = LEN_HH;
            spec_phase = PH_CONV;
        end
        if (hit) begin
            count_used();
            return 1'b0;
        end

        // Spec ends here: a conversion character is consumed, anything else is not.
        if (is_conversion(c)) count_used();
        r = spec_result(spec_flags, spec_width, spec_prec, spec_dot, spec_len,
                        is_conversion(c) ? c : 8'h00, is_conversion(c), spec_used,
                        is_conversion(c));
        spec_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // Offer one byte, hold it until taken, then advance the parse.
    task automatic push_byte(input logic [7:0] ch, input logic first, input bit typed,
                             input t_result typed_res);
        t_result r;
        bit      ignored;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        ignored = !first && spec_phase == PH_IDLE;
        if (parse_spec_byte(ch, first, r))
            pending_specs.push_back(typed ? typed_res : r);
        if (!ignored) useful_items++;
    endtask

    // One random spec: mostly well formed, some cut short, some noise.
    task automatic send_random_spec();
        logic [7:0] bq[$];
        int         kind;
        int         n;
        kind = $urandom_range(0, 99);
        if (kind >= 85 && kind < 92) begin
            // stray bytes without a start marker
            n = $urandom_range(1, 3);
            repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            return;
        end
        if (kind >= 92) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 255)),
                          (i == 0) ? 1'b1 : ($urandom_range(0, 9) == 0), 1'b0, '0);
            return;
        end

        // flags; now and then a run long enough to pin the byte count
        n = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 3);
        repeat (n) bq.push_back(flag_chars[$urandom_range(0, 4)]);
        if ($urandom_range(0, 1)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 4);
            bq.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
            repeat (n - 1) bq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 99) < 40) begin
            bq.push_back(CH_DOT);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 4);
            repeat (n) bq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        case ($urandom_range(0, 9))
            0: bq.push_back(CH_L);
            1: begin bq.push_back(CH_L); bq.push_back(CH_L); end
            2: bq.push_back(CH_H);
            3: begin bq.push_back(CH_H); bq.push_back(CH_H); end
            4: bq.push_back(CH_J);
            5: bq.push_back(CH_Z);
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            bq.push_back(8'($urandom_range(0, 255)));
        else
            bq.push_back(conv_chars[$urandom_range(0, 14)]);
        // drop the tail so the next start marker cuts the spec off
        if (kind >= 75 && bq.size() > 1)
            bq = bq[0:$urandom_range(0, bq.size() - 2)];
        foreach (bq[i]) push_byte(bq[i], i == 0, 1'b0, '0);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Result side: random stall, set per cycle by the active idling phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Compare every taken result with the oldest pending spec.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_spec = t_result'(m_axis_tdata);
            if (pending_specs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                fail_cnt++;
            end else begin
                want_spec = pending_specs.pop_front();
                cmp_field("flag_bits",    16'(want_spec.flag_bits),    16'(got_spec.flag_bits));
                cmp_field("field_width",  want_spec.field_width,       got_spec.field_width);
                cmp_field("prec_value",   want_spec.prec_value,        got_spec.prec_value);
                cmp_field("prec_given",   16'(want_spec.prec_given),   16'(got_spec.prec_given));
                cmp_field("length_code",  16'(want_spec.length_code),  16'(got_spec.length_code));
                cmp_field("conv_char",    16'(want_spec.conv_char),    16'(got_spec.conv_char));
                cmp_field("conv_found",   16'(want_spec.conv_found),   16'(got_spec.conv_found));
                cmp_field("bytes_used",   16'(want_spec.bytes_used),   16'(got_spec.bytes_used));
                cmp_field("end_consumed", 16'(want_spec.end_consumed), 16'(got_spec.end_consumed));
                cmp_field("pad",          16'(want_spec.pad),          16'(got_spec.pad));
            end
        end
    end

    initial begin
        // Directed table: a lone percent, an ignored byte, every flag with width,
        // precision and hh, a zero byte, ll, a spec cut off by a new start, the top
        // byte value, and a length with nothing valid after it.
        directed_tbl.push_back('{"%", 1'b1, 1'b1,
            spec_result('0, '0, '0, 1'b0, LEN_NONE, "%", 1'b1, 8'd1, 1'b1)});
        directed_tbl.push_back('{"x", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"#", 1'b1, 1'b0, '0});
        directed_tbl.push_back('{" ", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"+", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"-", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"0", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"9", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"9", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{".", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"3", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"h", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"h", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"d", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{8'h00, 1'b1, 1'b1,
            spec_result('0, '0, '0, 1'b0, LEN_NONE, 8'h00, 1'b0, 8'd0, 1'b0)});
        directed_tbl.push_back('{"l", 1'b1, 1'b0, '0});
        directed_tbl.push_back('{"l", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"X", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{"-", 1'b1, 1'b0, '0});
        directed_tbl.push_back('{"z", 1'b1, 1'b0, '0});
        directed_tbl.push_back('{"u", 1'b0, 1'b0, '0});
        directed_tbl.push_back('{8'hFF, 1'b1, 1'b1,
            spec_result('0, '0, '0, 1'b0, LEN_NONE, 8'h00, 1'b0, 8'd0, 1'b0)});
        directed_tbl.push_back('{"j", 1'b1, 1'b0, '0});
        directed_tbl.push_back('{"q", 1'b0, 1'b1,
            spec_result('0, '0, '0, 1'b0, LEN_J, 8'h00, 1'b0, 8'd1, 1'b0)});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[i])
            push_byte(directed_tbl[i].ch, directed_tbl[i].first, directed_tbl[i].typed,
                      directed_tbl[i].res);

        // Random part, stepping through the idling phases by item count.
        while (useful_items < 1550) begin
            if (useful_items < 420) begin
                tx_idle_pct = 0;   rx_stall_pct = 0;
            end else if (useful_items < 800) begin
                tx_idle_pct = 62;  rx_stall_pct = 0;
            end else if (useful_items < 1180) begin
                tx_idle_pct = 0;   rx_stall_pct = 62;
            end else begin
                tx_idle_pct = 15;  rx_stall_pct = 15;
            end
            send_random_spec();
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give a stray extra result time to show up.
        while (pending_specs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
